### sv/lz78_pkg.sv
// Package for the LZ78 phrase encoder: constants and request types.
// No dependencies.
`timescale 1ns / 1ps
package lz78_pkg;
    localparam int DictSizeDefault = 4096;
    localparam logic [7:0] EndMark = 8'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [11:0] phrase_code;
        logic [7:0]  next_byte;
        logic        final_flush;
    } t_out_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_CLEAR
    } t_state;
endpackage

### sv/lz78_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lz78_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/lz78_phrase_encoder_top.sv
// LZ78 phrase encoder top level. Uses lz78_pkg and lz78_ram.
// Child lookup: a hash table of codes, indexed by hash(node, byte), linear probing.
// Each byte is taken in idle and then passes the probe and check states; each extra
// probe repeats both, and no new byte is taken before the last is through. A stream
// end adds a clearing pass over all 2*DictSize table slots; no request is taken then.
// Reset: the block runs the same clearing pass once after reset.
`timescale 1ns / 1ps
module lz78_phrase_encoder_top #(
    parameter int DictSize = lz78_pkg::DictSizeDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lz78_pkg::t_in_req  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output lz78_pkg::t_out_req o_data
);
    import lz78_pkg::*;

    // table is twice the dictionary so probes always end at an empty slot
    localparam int CW = $clog2(DictSize);
    localparam int HD = 2 * DictSize;
    localparam int HW = $clog2(HD);
    localparam int EW = CW + CW + 8;

    t_state r_state, n_state;
    logic [CW-1:0] r_node;
    logic [CW:0]   r_free;
    logic [HW-1:0] r_slot;
    logic [HW:0]   r_clr;
    t_in_req       r_req;
    logic          r_ov;
    t_out_req      r_out;

    logic          we;
    logic [HW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [HW-1:0] hash;

    // entry layout: {code, parent, byte}; code 0 marks an empty slot
    lz78_ram #(.Width(EW), .Depth(HD)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // fold node and byte into a slot index
    always_comb begin
        logic [CW+7:0] key;
        key  = {i_data.data_byte, r_node};
        hash = HW'(key) ^ HW'(key >> HW) ^ HW'(key >> (2 * HW));
    end

    logic [CW-1:0] e_code, e_par;
    logic [7:0]    e_byte;
    logic          hit, empty, room, acc;
    assign e_code = rdata[EW-1 -: CW];
    assign e_par  = rdata[8 +: CW];
    assign e_byte = rdata[7:0];
    assign empty  = (e_code == '0);
    assign hit    = !empty && e_par == r_node && e_byte == r_req.data_byte;
    assign room   = r_free < (CW+1)'(DictSize);
    assign acc    = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || (r_ov && i_stall);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (acc) n_state = ST_PROBE;
            ST_PROBE: n_state = ST_CHECK;
            ST_CHECK: begin
                if (!hit && !empty) n_state = ST_PROBE;
                else if (r_req.last_byte) n_state = ST_CLEAR;
                else n_state = ST_IDLE;
            end
            ST_CLEAR: if (r_clr == (HW+1)'(HD - 1)) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        raddr = r_slot;
        if (r_state == ST_IDLE) raddr = hash;
        we    = 1'b0;
        waddr = r_slot;
        wdata = {CW'(r_free), r_node, r_req.data_byte};
        unique case (r_state)
            ST_CHECK: we = empty && room;
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr[HW-1:0];
                wdata = '0;
            end
            default: we = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_node  <= '0;
            r_free  <= (CW+1)'(1);
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: r_clr <= '0;
                ST_CHECK: begin
                    if (hit) begin
                        r_node <= e_code;
                        if (r_req.last_byte) r_ov <= 1'b1;
                    end else if (empty) begin
                        r_node <= '0;
                        r_ov   <= 1'b1;
                        if (room) r_free <= r_free + 1'b1;
                    end
                    if ((hit || empty) && r_req.last_byte) begin
                        r_node <= '0;
                        r_free <= (CW+1)'(1);
                    end
                end
                ST_CLEAR: r_clr <= r_clr + 1'b1;
                default: r_clr <= r_clr;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req  <= i_data;
            r_slot <= hash;
        end else if (r_state == ST_CHECK && !hit && !empty) begin
            r_slot <= r_slot + 1'b1;
        end
        if (r_state == ST_CHECK) begin
            if (hit) begin
                r_out.phrase_code <= 12'(e_code);
                r_out.next_byte   <= EndMark;
                r_out.final_flush <= 1'b1;
            end else if (empty) begin
                r_out.phrase_code <= 12'(r_node);
                r_out.next_byte   <= r_req.data_byte;
                r_out.final_flush <= 1'b0;
            end
        end
    end
endmodule
